@@ design/crp_pkg.sv @@
// Shared types and constants for the Catmull-Rom path interpolator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package crp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int MAX_STEPS_DEF   = 31;
    localparam int STEP_W          = 5;

    localparam logic [STEP_W-1:0] STEPS_RESET = STEP_W'(8);

    typedef enum logic [1:0] {
        KIND_FIRST,
        KIND_MID,
        KIND_LAST,
        KIND_LIN
    } t_kind;

    typedef struct packed {
        logic              load;
        logic              setup1;
        logic              setup2;
        logic              setup3;
        logic              div_start;
        logic              emit_sample;
        logic              emit_point;
        logic              run_end;
        t_kind             kind;
        logic [STEP_W-1:0] n;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
    } t_dp_status;

endpackage

`default_nettype wire

@@ design/crp_div.sv @@
// Restoring divider, one quotient bit per cycle, for the path interpolator.
// Standalone; the dividend must be below divisor * 2**Q_W.
`default_nettype none

module crp_div #(
    parameter int Q_W   = 34,
    parameter int DEN_W = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [Q_W+DEN_W-1:0]   i_dividend,
    input  wire logic [DEN_W-1:0]       i_divisor,
    output logic                        o_busy,
    output logic [Q_W-1:0]              o_quotient
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] r_rem, n_rem;
    logic [Q_W-1:0]   r_sh, n_sh;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    always_comb begin
        trial = {r_rem, r_sh[Q_W-1]};
        diff  = trial - {1'b0, r_den};
        n_rem = r_rem;
        n_sh  = r_sh;
        n_cnt = r_cnt;
        if (i_start) begin
            n_rem = i_dividend[Q_W+DEN_W-1:Q_W];
            n_sh  = i_dividend[Q_W-1:0];
            n_cnt = CNT_W'(Q_W);
        end else if (r_cnt != '0) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = diff[DEN_W-1:0];
                n_sh  = {r_sh[Q_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DEN_W-1:0];
                n_sh  = {r_sh[Q_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_sh  <= n_sh;
        if (i_start) begin
            r_den <= i_divisor;
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_sh;

endmodule

`default_nettype wire

@@ design/crp_axis.sv @@
// One coordinate lane: waypoint window, basis setup, forward differences,
// divider and saturation. Depends on crp_pkg and crp_div.
`default_nettype none

module crp_axis #(
    parameter int CW    = 32,
    parameter int DEN_W = 16,
    parameter int ACC_W = 54
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire crp_pkg::t_dp_cmd              i_cmd,
    input  wire logic signed [CW-1:0]          i_coord,
    input  wire logic [2*crp_pkg::STEP_W-1:0]  i_nn,
    input  wire logic [DEN_W-1:0]              i_den,
    input  wire logic [DEN_W-1:0]              i_rnd,
    output logic                               o_busy,
    output logic signed [CW-1:0]               o_q
);

    localparam int Q_W   = CW + 2;
    localparam int DVD_W = Q_W + DEN_W;
    localparam int S1_W  = CW + 1;
    localparam int S2_W  = CW + 4;
    localparam int S3_W  = CW + 3;
    localparam int NN_W  = 2 * crp_pkg::STEP_W;
    localparam int P2_W  = S2_W + crp_pkg::STEP_W + 1;
    localparam int P1_W  = S1_W + NN_W + 1;
    localparam int SUM_W = Q_W + 1;

    localparam logic signed [CW-1:0] C_MAX = signed'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [CW-1:0] C_MIN = signed'({1'b1, {(CW-1){1'b0}}});

    logic signed [CW-1:0]    r_w [4];
    logic signed [CW-1:0]    r_base;
    logic signed [S1_W-1:0]  r_s1;
    logic signed [S2_W-1:0]  r_s2;
    logic signed [S3_W-1:0]  r_s3;
    logic signed [ACC_W-1:0] r_a1, r_a2;
    logic signed [ACC_W-1:0] r_acc, r_d1, r_d2, r_d3;
    logic signed [CW-1:0]    r_q;

    logic signed [CW-1:0]    p0, p1, p2, p3;
    logic signed [S1_W-1:0]  s1;
    logic signed [S2_W-1:0]  s2;
    logic signed [S3_W-1:0]  s3;
    logic signed [crp_pkg::STEP_W:0] n_s;
    logic signed [NN_W:0]    nn_s;
    logic signed [P2_W-1:0]  prod2;
    logic signed [P1_W-1:0]  prod1;
    logic signed [ACC_W-1:0] s3e, d3_init;
    logic [ACC_W-1:0]        dvd_full;
    logic [Q_W-1:0]          quot;
    logic signed [Q_W-1:0]   qrel;
    logic signed [SUM_W-1:0] sum;
    logic signed [CW-1:0]    sample;

    always_comb begin
        unique case (i_cmd.kind)
            crp_pkg::KIND_FIRST: begin
                p0 = r_w[1]; p1 = r_w[1]; p2 = r_w[2]; p3 = r_w[3];
            end
            crp_pkg::KIND_MID: begin
                p0 = r_w[0]; p1 = r_w[1]; p2 = r_w[2]; p3 = r_w[3];
            end
            crp_pkg::KIND_LAST: begin
                p0 = r_w[1]; p1 = r_w[2]; p2 = r_w[3]; p3 = r_w[3];
            end
            crp_pkg::KIND_LIN: begin
                p0 = r_w[2]; p1 = r_w[2]; p2 = r_w[3]; p3 = r_w[3];
            end
        endcase
    end

    assign s1 = S1_W'(p2) - S1_W'(p0);
    assign s3 = S3_W'(p3) - S3_W'(p0)
              + ((S3_W'(p1) - S3_W'(p2)) <<< 1) + (S3_W'(p1) - S3_W'(p2));
    assign s2 = (S2_W'(p0) <<< 1) - (S2_W'(p1) <<< 2) - S2_W'(p1)
              + (S2_W'(p2) <<< 2) - S2_W'(p3);

    assign n_s   = signed'({1'b0, i_cmd.n});
    assign nn_s  = signed'({1'b0, i_nn});
    assign prod2 = r_s2 * n_s;
    assign prod1 = r_s1 * nn_s;

    assign s3e     = ACC_W'(r_s3);
    assign d3_init = (s3e <<< 2) + (s3e <<< 1);

    assign dvd_full = $unsigned(r_acc) + ACC_W'(i_rnd) + (ACC_W'(i_den) << (CW + 1));

    crp_div #(
        .Q_W   (Q_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd_full[DVD_W-1:0]),
        .i_divisor  (i_den),
        .o_busy     (o_busy),
        .o_quotient (quot)
    );

    assign qrel = signed'({~quot[Q_W-1], quot[Q_W-2:0]});
    assign sum  = SUM_W'(qrel) + SUM_W'(r_base);

    always_comb begin
        if (sum > SUM_W'(C_MAX)) begin
            sample = C_MAX;
        end else if (sum < SUM_W'(C_MIN)) begin
            sample = C_MIN;
        end else begin
            sample = sum[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w[0] <= r_w[1];
            r_w[1] <= r_w[2];
            r_w[2] <= r_w[3];
            r_w[3] <= i_coord;
        end
        if (i_cmd.setup1) begin
            r_base <= p1;
            r_s1   <= s1;
            r_s2   <= s2;
            r_s3   <= s3;
        end
        if (i_cmd.setup2) begin
            r_a2 <= ACC_W'(prod2);
            r_a1 <= ACC_W'(prod1);
        end
        if (i_cmd.setup3) begin
            r_acc <= '0;
            if (i_cmd.kind == crp_pkg::KIND_LIN) begin
                r_d1 <= ACC_W'(r_s1);
                r_d2 <= '0;
                r_d3 <= '0;
            end else begin
                r_d1 <= s3e + r_a2 + r_a1;
                r_d2 <= d3_init + (r_a2 <<< 1);
                r_d3 <= d3_init;
            end
        end
        if (i_cmd.emit_sample) begin
            r_acc <= r_acc + r_d1;
            r_d1  <= r_d1 + r_d2;
            r_d2  <= r_d2 + r_d3;
            r_q   <= sample;
        end
        if (i_cmd.emit_point) begin
            r_q <= r_w[3];
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

@@ design/crp_datapath.sv @@
// Datapath of the path interpolator: step-count powers, divisor and rounding
// terms, two coordinate lanes and the output payload. Depends on crp_pkg, crp_axis.
`default_nettype none

module crp_datapath #(
    parameter int COORD_WIDTH = crp_pkg::COORD_WIDTH_DEF,
    parameter int MAX_STEPS   = crp_pkg::MAX_STEPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire crp_pkg::t_dp_cmd              i_cmd,
    input  wire logic signed [COORD_WIDTH-1:0] i_px,
    input  wire logic signed [COORD_WIDTH-1:0] i_py,
    output crp_pkg::t_dp_status                o_status,
    output logic signed [COORD_WIDTH-1:0]      o_qx,
    output logic signed [COORD_WIDTH-1:0]      o_qy,
    output logic                               o_run_end
);

    localparam int DEN_W = $clog2(2 * MAX_STEPS**3 + 1);
    localparam int ACC_W = COORD_WIDTH + DEN_W + 6;
    localparam int NN_W  = 2 * crp_pkg::STEP_W;
    localparam int N3_W  = 3 * crp_pkg::STEP_W;

    logic [NN_W-1:0]  r_nn;
    logic [N3_W-1:0]  r_n3;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rnd;
    logic             r_run_end;
    logic             busy_x, busy_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup1) begin
            r_nn <= NN_W'(i_cmd.n) * NN_W'(i_cmd.n);
        end
        if (i_cmd.setup2) begin
            r_n3 <= N3_W'(r_nn) * N3_W'(i_cmd.n);
        end
        if (i_cmd.setup3) begin
            if (i_cmd.kind == crp_pkg::KIND_LIN) begin
                r_den <= DEN_W'(i_cmd.n);
                r_rnd <= DEN_W'(i_cmd.n >> 1);
            end else begin
                r_den <= DEN_W'({r_n3, 1'b0});
                r_rnd <= DEN_W'(r_n3);
            end
        end
        if (i_cmd.emit_sample || i_cmd.emit_point) begin
            r_run_end <= i_cmd.run_end;
        end
    end

    crp_axis #(
        .CW    (COORD_WIDTH),
        .DEN_W (DEN_W),
        .ACC_W (ACC_W)
    ) u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_coord (i_px),
        .i_nn    (r_nn),
        .i_den   (r_den),
        .i_rnd   (r_rnd),
        .o_busy  (busy_x),
        .o_q     (o_qx)
    );

    crp_axis #(
        .CW    (COORD_WIDTH),
        .DEN_W (DEN_W),
        .ACC_W (ACC_W)
    ) u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_coord (i_py),
        .i_nn    (r_nn),
        .i_den   (r_den),
        .i_rnd   (r_rnd),
        .o_busy  (busy_y),
        .o_q     (o_qy)
    );

    assign o_status.div_busy = busy_x | busy_y;
    assign o_run_end         = r_run_end;

endmodule

`default_nettype wire

@@ design/crp_ctrl.sv @@
// Controller of the path interpolator: input and output handshakes, step
// register, waypoint count and segment sequencing. Depends on crp_pkg.
`default_nettype none

module crp_ctrl #(
    parameter int MAX_STEPS = crp_pkg::MAX_STEPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_path_end,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic                          i_cfg_valid,
    input  wire logic [crp_pkg::STEP_W-1:0]    i_cfg_data,
    output logic                               o_cfg_ready,
    output crp_pkg::t_dp_cmd                   o_cmd,
    input  wire crp_pkg::t_dp_status           i_status
);

    localparam int SW = crp_pkg::STEP_W;
    localparam logic [SW-1:0] STEPS_MAX = SW'(MAX_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP1,
        ST_SETUP2,
        ST_SETUP3,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_POINT
    } t_state;

    t_state           r_state, n_state;
    logic [SW-1:0]    r_steps, n_steps;
    logic [1:0]       r_seen, n_seen;
    crp_pkg::t_kind   r_kind, n_kind;
    logic             r_last, n_last;
    logic [SW-1:0]    r_n, n_n;
    logic [SW-1:0]    r_j, n_j;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    logic [SW-1:0]    steps_eff;
    logic [SW-1:0]    j_last;

    always_comb begin
        if (r_steps == '0) begin
            steps_eff = SW'(1);
        end else if (r_steps > STEPS_MAX) begin
            steps_eff = STEPS_MAX;
        end else begin
            steps_eff = r_steps;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign j_last   = (r_kind == crp_pkg::KIND_LIN) ? r_n : r_n - 1'b1;

    always_comb begin
        n_state     = r_state;
        n_steps     = r_steps;
        n_seen      = r_seen;
        n_kind      = r_kind;
        n_last      = r_last;
        n_n         = r_n;
        n_j         = r_j;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.kind  = r_kind;
        o_cmd.n     = r_n;

        if (i_cfg_valid) begin
            n_steps = i_cfg_data;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_last     = i_path_end;
                    n_n        = steps_eff;
                    if (i_path_end) begin
                        n_seen = 2'd0;
                    end else if (r_seen != 2'd3) begin
                        n_seen = r_seen + 2'd1;
                    end
                    if (r_seen >= 2'd2) begin
                        n_kind  = (r_seen == 2'd2) ? crp_pkg::KIND_FIRST : crp_pkg::KIND_MID;
                        n_state = ST_SETUP1;
                    end else if (i_path_end && r_seen == 2'd1) begin
                        n_kind  = crp_pkg::KIND_LIN;
                        n_state = ST_SETUP1;
                    end else if (i_path_end) begin
                        n_state = ST_POINT;
                    end
                end
            end
            ST_SETUP1: begin
                o_cmd.setup1 = 1'b1;
                n_j          = '0;
                n_state      = ST_SETUP2;
            end
            ST_SETUP2: begin
                o_cmd.setup2 = 1'b1;
                n_state      = ST_SETUP3;
            end
            ST_SETUP3: begin
                o_cmd.setup3 = 1'b1;
                n_state      = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!i_status.div_busy && out_free) begin
                    o_cmd.emit_sample = 1'b1;
                    n_out_valid       = 1'b1;
                    if (r_j == j_last) begin
                        unique case (r_kind) inside
                            crp_pkg::KIND_FIRST, crp_pkg::KIND_MID: begin
                                o_cmd.run_end = !r_last;
                                if (r_last) begin
                                    n_kind  = crp_pkg::KIND_LAST;
                                    n_state = ST_SETUP1;
                                end else begin
                                    n_state = ST_IDLE;
                                end
                            end
                            crp_pkg::KIND_LAST: begin
                                n_state = ST_POINT;
                            end
                            crp_pkg::KIND_LIN: begin
                                o_cmd.run_end = 1'b1;
                                n_state       = ST_IDLE;
                            end
                        endcase
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = ST_DIV_GO;
                    end
                end
            end
            ST_POINT: begin
                if (out_free) begin
                    o_cmd.emit_point = 1'b1;
                    o_cmd.run_end    = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_steps     <= crp_pkg::STEPS_RESET;
            r_seen      <= 2'd0;
            r_kind      <= crp_pkg::KIND_FIRST;
            r_last      <= 1'b0;
            r_n         <= SW'(1);
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_steps     <= n_steps;
            r_seen      <= n_seen;
            r_kind      <= n_kind;
            r_last      <= n_last;
            r_n         <= n_n;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

@@ design/catmull_rom_path_interpolator.sv @@
// Catmull-Rom path interpolator, top level: controller plus datapath.
// Depends on crp_pkg, crp_ctrl and crp_datapath.
//
// Input channel (i_in_valid / o_in_stall) takes one waypoint per transaction;
// i_path_end marks the last point of a path. Output channel (o_out_valid /
// i_out_stall) delivers samples; o_run_end flags the last sample of a waypoint.
// The cfg channel (i_cfg_valid / o_cfg_ready, always ready) sets the samples
// per segment N; 0 acts as 1, values above MAX_STEPS act as MAX_STEPS.
// One waypoint is worked on at a time. A point that opens a segment first
// sets up the basis and the forward differences, then computes each sample
// with the one-bit-per-cycle restoring divider that each lane runs in parallel.
// A final point adds a second segment and the exact endpoint. Points that
// cause no sample only shift the waypoint window.
// The sample register holds while i_out_stall is high; the next sample is
// computed meanwhile and waits for the register to free up.
// Synchronous reset clears the point count, empties the output register and
// sets N to 8; stored waypoints are not cleared.
`default_nettype none

module catmull_rom_path_interpolator #(
    parameter int COORD_WIDTH = crp_pkg::COORD_WIDTH_DEF,
    parameter int MAX_STEPS   = crp_pkg::MAX_STEPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_px,
    input  wire logic signed [COORD_WIDTH-1:0] i_py,
    input  wire logic                          i_path_end,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [COORD_WIDTH-1:0]      o_qx,
    output logic signed [COORD_WIDTH-1:0]      o_qy,
    output logic                               o_run_end,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [crp_pkg::STEP_W-1:0]    i_cfg_data
);

    crp_pkg::t_dp_cmd    cmd;
    crp_pkg::t_dp_status status;

    crp_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_path_end  (i_path_end),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    crp_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .MAX_STEPS   (MAX_STEPS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_px      (i_px),
        .i_py      (i_py),
        .o_status  (status),
        .o_qx      (o_qx),
        .o_qy      (o_qy),
        .o_run_end (o_run_end)
    );

endmodule

`default_nettype wire

@@ sim/catmull_rom_path_interpolator_test.sv @@
// Self-checking testbench for catmull_rom_path_interpolator: drives waypoint paths,
// predicts every spline, linear and pass-through sample in fixed point and compares.
// Depends on crp_pkg and the catmull_rom_path_interpolator top level.
`default_nettype none

module catmull_rom_path_interpolator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW            = crp_pkg::COORD_WIDTH_DEF;
    localparam int SW            = crp_pkg::STEP_W;
    localparam int SAMPLE_CYCLES = CW + 4;
    localparam int SETTLE_CYCLES = 2 * SAMPLE_CYCLES;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 36;

    typedef logic signed [CW-1:0] t_coord;

    localparam t_coord C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord C_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        t_coord qx;
        t_coord qy;
        logic   run_end;
    } t_sample;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              in_valid   = 1'b0;
    t_coord            px         = '0;
    t_coord            py         = '0;
    logic              path_end   = 1'b0;
    logic              out_stall  = 1'b0;
    logic              cfg_valid  = 1'b0;
    logic [SW-1:0]     cfg_data   = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_coord            o_qx;
    t_coord            o_qy;
    logic              o_run_end;
    logic              o_cfg_ready;

    t_sample           sample_q[$];
    longint            path_x[3];
    longint            path_y[3];
    int                points_held    = 0;
    logic [SW-1:0]     steps_reg      = crp_pkg::STEPS_RESET;
    int                samples_left   = 0;
    int                err_cnt        = 0;
    int                src_idle_pct   = 0;
    int                sink_stall_pct = 0;
    bit                hold_req       = 1'b0;
    int                hold_left      = 0;

    catmull_rom_path_interpolator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_px        (px),
        .i_py        (py),
        .i_path_end  (path_end),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_qx        (o_qx),
        .o_qy        (o_qy),
        .o_run_end   (o_run_end),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint floor_quot(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        return q;
    endfunction

    function automatic t_coord clamp_coord(input longint v);
        if (v > longint'(C_MAX)) return C_MAX;
        if (v < longint'(C_MIN)) return C_MIN;
        return t_coord'(v);
    endfunction

    function automatic longint spline_at(input longint n, input longint j, input longint a,
                                         input longint b, input longint c, input longint d);
        longint j2, j3, n2, n3;
        j2 = j * j;
        j3 = j2 * j;
        n2 = n * n;
        n3 = n2 * n;
        return floor_quot((-j3 + 2 * j2 * n - j * n2) * a + (3 * j3 - 5 * j2 * n + 2 * n3) * b
                          + (-3 * j3 + 4 * j2 * n + j * n2) * c + (j3 - j2 * n) * d + n3,
                          2 * n3);
    endfunction

    function automatic void add_sample(input longint x, input longint y);
        t_sample s;
        s.qx      = clamp_coord(x);
        s.qy      = clamp_coord(y);
        s.run_end = (samples_left == 1);
        samples_left--;
        sample_q = {sample_q, s};
    endfunction

    function automatic void predict_waypoint(input t_coord x_in, input t_coord y_in,
                                             input logic is_end);
        longint x, y, n, ax, ay, j;
        x = x_in;
        y = y_in;
        if (steps_reg == 0) n = 1;
        else if (steps_reg > crp_pkg::MAX_STEPS_DEF) n = crp_pkg::MAX_STEPS_DEF;
        else n = steps_reg;

        if (points_held >= 2) samples_left = is_end ? 2 * n + 1 : n;
        else if (is_end) samples_left = (points_held == 1) ? n + 1 : 1;
        else samples_left = 0;

        if (points_held >= 2) begin
            ax = (points_held == 2) ? path_x[1] : path_x[0];
            ay = (points_held == 2) ? path_y[1] : path_y[0];
            for (j = 0; j < n; j++)
                add_sample(spline_at(n, j, ax, path_x[1], path_x[2], x),
                           spline_at(n, j, ay, path_y[1], path_y[2], y));
            if (is_end) begin
                // clamp the outer control point to the final waypoint
                for (j = 0; j < n; j++)
                    add_sample(spline_at(n, j, path_x[1], path_x[2], x, x),
                               spline_at(n, j, path_y[1], path_y[2], y, y));
                add_sample(x, y);
            end
        end else if (is_end) begin
            if (points_held == 1) begin
                for (j = 0; j <= n; j++)
                    add_sample(floor_quot(path_x[2] * (n - j) + x * j + n / 2, n),
                               floor_quot(path_y[2] * (n - j) + y * j + n / 2, n));
            end else begin
                add_sample(x, y);
            end
        end

        path_x[0] = path_x[1];
        path_y[0] = path_y[1];
        path_x[1] = path_x[2];
        path_y[1] = path_y[2];
        path_x[2] = x;
        path_y[2] = y;
        if (is_end) points_held = 0;
        else if (points_held < 3) points_held++;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(9)) inside
            0: return $urandom_range(1) ? C_MAX - t_coord'($urandom_range(3))
                                        : C_MIN + t_coord'($urandom_range(3));
            1, 2, 3: return t_coord'($urandom);
            default: return t_coord'(int'($urandom_range(2097152)) - 1048576);
        endcase
    endfunction

    task automatic send_point(input t_coord x, input t_coord y, input logic is_end);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        px       <= x;
        py       <= y;
        path_end <= is_end;
        do @(posedge i_clk); while (o_in_stall);
        predict_waypoint(x, y, is_end);
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_segment_steps(input logic [SW-1:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        steps_reg = value;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_sample
        t_sample got, want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            got.qx      = o_qx;
            got.qy      = o_qy;
            got.run_end = o_run_end;
            if (sample_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("unexpected sample qx=%0d qy=%0d run_end=%0b",
                             got.qx, got.qy, got.run_end);
            end else begin
                want = sample_q.pop_front();
                if (got.qx !== want.qx || got.qy !== want.qy || got.run_end !== want.run_end)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("sample mismatch: expected qx=%0d qy=%0d run_end=%0b,",
                                 want.qx, want.qy, want.run_end,
                                 " got qx=%0d qy=%0d run_end=%0b",
                                 got.qx, got.qy, got.run_end);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic test_lone_points();
        send_point('0, '0, 1'b1);
        send_point(C_MAX, C_MIN, 1'b1);
        send_point('1, t_coord'(1), 1'b1);
        settle();
    endtask

    task automatic test_two_point_paths();
        send_point(C_MIN, C_MAX, 1'b0);
        send_point(C_MAX, C_MIN, 1'b1);
        send_point(t_coord'(-196608), t_coord'(65536), 1'b0);
        send_point(t_coord'(5), t_coord'(-7), 1'b1);
        settle();
    endtask

    task automatic test_spline_paths();
        send_point('0, '0, 1'b0);
        send_point(t_coord'(65536), t_coord'(131072), 1'b0);
        send_point(t_coord'(196608), t_coord'(-65536), 1'b1);
        send_point(t_coord'(-1000), t_coord'(7), 1'b0);
        send_point(t_coord'(123457), t_coord'(-99999), 1'b0);
        send_point(t_coord'(-65535), t_coord'(400000), 1'b0);
        send_point(t_coord'(333333), t_coord'(3), 1'b0);
        send_point(t_coord'(17), t_coord'(-250001), 1'b1);
        settle();
    endtask

    task automatic test_saturation();
        send_point(C_MAX, C_MIN, 1'b0);
        send_point(C_MIN, C_MAX, 1'b0);
        send_point(C_MAX, C_MIN, 1'b0);
        send_point(C_MIN, C_MAX, 1'b1);
        settle();
    endtask

    task automatic test_step_extremes();
        write_segment_steps('0);
        send_point(t_coord'(10), t_coord'(-20), 1'b0);
        send_point(t_coord'(70000), t_coord'(5), 1'b0);
        send_point(t_coord'(-3), t_coord'(90000), 1'b1);
        settle();
        write_segment_steps('1);
        send_point(t_coord'(-500000), t_coord'(12345), 1'b0);
        send_point(t_coord'(800000), t_coord'(-54321), 1'b0);
        send_point(t_coord'(100), t_coord'(100), 1'b0);
        settle();
        // change the step count with the path still open
        write_segment_steps(SW'(1));
        send_point(t_coord'(-77777), t_coord'(0), 1'b1);
        settle();
    endtask

    task automatic test_backpressure();
        int k;
        write_segment_steps(SW'(4));
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        @(posedge i_clk);
        hold_req = 1'b1;
        for (k = 0; k < 10; k++)
            send_point(rand_coord(), rand_coord(), k == 9);
        settle();
    endtask

    task automatic run_random_phase(input int src_pct, input int sink_pct);
        int sent, len, k, pick;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        if ($urandom_range(7) == 0) write_segment_steps($urandom_range(1) ? '1 : '0);
        else write_segment_steps(SW'($urandom_range(1, 8)));
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(19);
            if (pick < 2) len = 1;
            else if (pick < 5) len = 2;
            else len = $urandom_range(3, 9);
            for (k = 0; k < len; k++)
                send_point(rand_coord(), rand_coord(), k == len - 1);
            sent += len;
        end
        // may leave a path open across the next step change
        repeat ($urandom_range(3)) send_point(rand_coord(), rand_coord(), 1'b0);
        settle();
    endtask

    task automatic test_random_paths();
        run_random_phase(0, 0);
        run_random_phase(0, 0);
        run_random_phase(76, 0);
        run_random_phase(76, 0);
        run_random_phase(0, 76);
        run_random_phase(0, 76);
        run_random_phase(24, 24);
        run_random_phase(24, 24);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_lone_points();
        test_two_point_paths();
        test_spline_paths();
        test_saturation();
        test_step_extremes();
        test_backpressure();
        test_random_paths();
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
